### rtl/boi_pkg.sv
// shared types, constants and the arctangent table for the odometry integrator
// no dependencies
package boi_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CNT_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

    localparam int CW      = 35;
    localparam int DIV_W   = 48;
    localparam int DVS_W   = 34;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [CW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [CW-1:0] GAIN_Q30    = 35'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 35'sd1073741824;

    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic signed [13:0] STEER_LIM  = 14'sd5734;

    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] z0;
    } t_cor_req;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 35'sh03243F6A8;
            5'd1:  v = 35'sh01DAC6705;
            5'd2:  v = 35'sh00FADBAFC;
            5'd3:  v = 35'sh007F56EA6;
            5'd4:  v = 35'sh003FEAB76;
            5'd5:  v = 35'sh001FFD55B;
            5'd6:  v = 35'sh000FFFAAA;
            5'd7:  v = 35'sh0007FFF55;
            5'd8:  v = 35'sh0003FFFEA;
            5'd9:  v = 35'sh0001FFFFD;
            5'd10: v = 35'sh0000FFFFF;
            5'd11: v = 35'sh00007FFFF;
            5'd12: v = 35'sh00003FFFF;
            5'd13: v = 35'sh00001FFFF;
            5'd14: v = 35'sh00000FFFF;
            5'd15: v = 35'sh000007FFF;
            5'd16: v = 35'sh000003FFF;
            5'd17: v = 35'sh000001FFF;
            5'd18: v = 35'sh000000FFF;
            5'd19: v = 35'sh0000007FF;
            5'd20: v = 35'sh0000003FF;
            5'd21: v = 35'sh0000001FF;
            5'd22: v = 35'sh0000000FF;
            5'd23: v = 35'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/bicycle_odometry_integrator.sv
// kinematic bicycle dead-reckoning integrator: sequencer, shared multiplier, pose state
// depends on boi_pkg, boi_cordic, boi_div
//
// usage
// - input channel (i_in_valid / o_in_ready) carries one item: action 0 is a drive
//   command (speed and steering), action 1 is an integration tick
// - a command gives no result; it takes one cordic pass, a division, a multiply and,
//   unless the wheelbase is zero, a second division
// - a tick takes one cordic pass plus seven multiply and update steps, then loads
//   the pose into the output register
// - o_in_ready is high only while the sequencer is idle, so one item at a time
//   uses the cordic, divider and multiplier
// - output channel (o_out_valid / i_out_ready) holds one pose; a new item is taken
//   while a pose waits, and a tick that finishes while the receiver stalls waits
//   in its last step until the register frees
// - configuration writes (wheelbase, time step) are accepted in every cycle
// - reset clears the pose, speeds and yaw rates and loads the default wheelbase
//   and time step; no clearing pass is needed
module bicycle_odometry_integrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [15:0] i_command_speed,
    input  logic signed [13:0] i_steer_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [14:0] o_heading,
    output logic signed [15:0] o_speed_out,
    output logic signed [15:0] o_yaw_rate_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam logic REG_WHEELBASE = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_C_COR  = 4'd1;
    localparam logic [3:0] S_C_DIV1 = 4'd2;
    localparam logic [3:0] S_C_MULI = 4'd3;
    localparam logic [3:0] S_C_MUL  = 4'd4;
    localparam logic [3:0] S_C_DIV2 = 4'd5;
    localparam logic [3:0] S_T_COR  = 4'd6;
    localparam logic [3:0] S_T_ST   = 4'd7;
    localparam logic [3:0] S_T_XL   = 4'd8;
    localparam logic [3:0] S_T_XH   = 4'd9;
    localparam logic [3:0] S_T_YL   = 4'd10;
    localparam logic [3:0] S_T_YH   = 4'd11;
    localparam logic [3:0] S_T_YAW  = 4'd12;
    localparam logic [3:0] S_T_FIN  = 4'd13;

    localparam int CW = boi_pkg::CW;

    localparam logic signed [13:0] STEER_LIM_P = boi_pkg::STEER_LIM;

    logic [3:0]                r_state;
    logic [15:0]               r_wheelbase, r_time_step;
    logic signed [31:0]        r_pos_x, r_pos_y;
    logic signed [14:0]        r_yaw;
    logic signed [15:0]        r_speed, r_yaw_rate, r_pend_speed, r_pend_yaw_rate;
    logic signed [15:0]        r_cmd_speed;
    logic                      r_flip, r_neg;
    logic signed [23:0]        r_tan;
    logic signed [CW-1:0]      r_c, r_s;
    logic signed [32:0]        r_st;
    logic signed [67:0]        r_acc;
    logic signed [33:0]        r_dx, r_dy;
    logic signed [16:0]        r_dyaw;
    logic signed [boi_pkg::PROD_W-1:0] r_prod;
    logic                      r_out_valid;
    logic signed [31:0]        r_o_x, r_o_y;
    logic signed [14:0]        r_o_heading;
    logic signed [15:0]        r_o_speed, r_o_yaw_rate;

    boi_pkg::t_cor_req         cor_req;
    boi_pkg::t_div_req         div_req;
    logic                      cor_done, div_done;
    logic signed [CW-1:0]      cor_x, cor_y;
    logic [boi_pkg::DIV_W-1:0] div_q;

    logic                      in_acc, out_free;
    logic signed [13:0]        steer_c;
    logic signed [CW-1:0]      z_tick, z_tick_adj, z_cmd;
    logic                      flip_tick;
    logic [CW-1:0]             abs_cy;
    logic [boi_pkg::PROD_W-1:0] abs_num;
    logic signed [boi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [boi_pkg::MUL_B_W-1:0] mul_b;
    logic signed [67:0]        hi_sh, sum_xy, sh_xy;
    logic signed [boi_pkg::PROD_W-1:0] yaw_t, yaw_sh;
    logic signed [34:0]        px, py;
    logic signed [17:0]        y0, y1, y2, y3, y4;
    logic signed [31:0]        px_sat, py_sat;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // command angle and tick angle folded into the cordic range
    always_comb begin
        if (i_steer_angle > STEER_LIM_P)
            steer_c = STEER_LIM_P;
        else if (i_steer_angle < -STEER_LIM_P)
            steer_c = -STEER_LIM_P;
        else
            steer_c = i_steer_angle;
        z_cmd  = CW'(steer_c) <<< 18;
        z_tick = CW'(r_yaw) <<< 18;
        if (z_tick > boi_pkg::HALF_PI_Q30) begin
            z_tick_adj = z_tick - boi_pkg::PI_Q30;
            flip_tick  = 1'b1;
        end else if (z_tick < -boi_pkg::HALF_PI_Q30) begin
            z_tick_adj = z_tick + boi_pkg::PI_Q30;
            flip_tick  = 1'b1;
        end else begin
            z_tick_adj = z_tick;
            flip_tick  = 1'b0;
        end
    end

    always_comb begin
        cor_req.start = in_acc;
        cor_req.x0    = i_action ? boi_pkg::GAIN_Q30 : boi_pkg::ONE_Q30;
        cor_req.z0    = i_action ? z_tick_adj : z_cmd;
    end

    boi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    always_comb begin
        abs_cy  = (cor_y < 0) ? CW'(-cor_y) : CW'(cor_y);
        abs_num = (r_prod < 0) ? boi_pkg::PROD_W'(-r_prod) : boi_pkg::PROD_W'(r_prod);
        div_req.start = ((r_state == S_C_COR) && cor_done) ||
                        ((r_state == S_C_MUL) && (r_wheelbase != 16'd0));
        if (r_state == S_C_COR) begin
            div_req.dividend = boi_pkg::DIV_W'(abs_cy) << 16;
            div_req.divisor  = (cor_x <= 0) ? boi_pkg::DVS_W'(1)
                                            : cor_x[boi_pkg::DVS_W-1:0];
        end else begin
            div_req.dividend = abs_num[boi_pkg::DIV_W-1:0];
            div_req.divisor  = boi_pkg::DVS_W'({r_wheelbase, 4'b0000});
        end
    end

    boi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // shared multiplier operand select, product registered every cycle
    always_comb begin
        case (r_state)
            S_C_MULI: begin
                mul_a = boi_pkg::MUL_A_W'(r_tan);
                mul_b = boi_pkg::MUL_B_W'(r_speed);
            end
            S_T_COR: begin
                mul_a = boi_pkg::MUL_A_W'(r_speed);
                mul_b = $signed({2'b00, r_time_step});
            end
            S_T_ST: begin
                mul_a = boi_pkg::MUL_A_W'($signed(r_prod[32:0]));
                mul_b = $signed({1'b0, r_c[16:0]});
            end
            S_T_XL: begin
                mul_a = boi_pkg::MUL_A_W'(r_st);
                mul_b = $signed(r_c[34:17]);
            end
            S_T_XH: begin
                mul_a = boi_pkg::MUL_A_W'(r_st);
                mul_b = $signed({1'b0, r_s[16:0]});
            end
            S_T_YL: begin
                mul_a = boi_pkg::MUL_A_W'(r_st);
                mul_b = $signed(r_s[34:17]);
            end
            S_T_YH: begin
                mul_a = boi_pkg::MUL_A_W'(r_yaw_rate);
                mul_b = $signed({2'b00, r_time_step});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        hi_sh  = 68'(r_prod) <<< 17;
        sum_xy = r_acc + hi_sh + (68'sd1 <<< 37);
        sh_xy  = sum_xy >>> 38;
        yaw_t  = r_prod + boi_pkg::PROD_W'(32768);
        yaw_sh = yaw_t >>> 16;
        px     = 35'(r_pos_x) + 35'(r_dx);
        py     = 35'(r_pos_y) + 35'(r_dy);
        if (px > 35'sd2147483647)
            px_sat = 32'sh7FFFFFFF;
        else if (px < -35'sd2147483648)
            px_sat = 32'sh80000000;
        else
            px_sat = px[31:0];
        if (py > 35'sd2147483647)
            py_sat = 32'sh7FFFFFFF;
        else if (py < -35'sd2147483648)
            py_sat = 32'sh80000000;
        else
            py_sat = py[31:0];
        y0 = 18'(r_yaw) + 18'(r_dyaw);
        y1 = (y0 > boi_pkg::PI_Q12) ? y0 - boi_pkg::TWO_PI_Q12 : y0;
        y2 = (y1 > boi_pkg::PI_Q12) ? y1 - boi_pkg::TWO_PI_Q12 : y1;
        y3 = (y2 <= -boi_pkg::PI_Q12) ? y2 + boi_pkg::TWO_PI_Q12 : y2;
        y4 = (y3 <= -boi_pkg::PI_Q12) ? y3 + boi_pkg::TWO_PI_Q12 : y3;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_wheelbase     <= 16'd548;
            r_time_step     <= 16'd6554;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_yaw           <= '0;
            r_speed         <= '0;
            r_yaw_rate      <= '0;
            r_pend_speed    <= '0;
            r_pend_yaw_rate <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WHEELBASE: r_wheelbase <= i_cfg_data;
                    REG_TIME_STEP: r_time_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd_speed <= i_command_speed;
                        r_flip      <= flip_tick;
                        r_state     <= i_action ? S_T_COR : S_C_COR;
                    end
                end
                S_C_COR: begin
                    if (cor_done) begin
                        r_neg   <= cor_y < 0;
                        r_state <= S_C_DIV1;
                    end
                end
                S_C_DIV1: begin
                    if (div_done) begin
                        r_tan   <= r_neg ? -$signed(div_q[23:0]) : $signed(div_q[23:0]);
                        r_state <= S_C_MULI;
                    end
                end
                S_C_MULI: r_state <= S_C_MUL;
                S_C_MUL: begin
                    r_neg <= r_prod < 0;
                    if (r_wheelbase == 16'd0) begin
                        if (r_prod > 0)
                            r_pend_yaw_rate <= 16'sh7FFF;
                        else if (r_prod < 0)
                            r_pend_yaw_rate <= 16'sh8000;
                        else
                            r_pend_yaw_rate <= '0;
                        r_pend_speed <= r_cmd_speed;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_C_DIV2;
                    end
                end
                S_C_DIV2: begin
                    if (div_done) begin
                        if (!r_neg)
                            r_pend_yaw_rate <= (div_q > boi_pkg::DIV_W'(32767))
                                             ? 16'sh7FFF : $signed(div_q[15:0]);
                        else
                            r_pend_yaw_rate <= (div_q >= boi_pkg::DIV_W'(32768))
                                             ? 16'sh8000 : -$signed(div_q[15:0]);
                        r_pend_speed <= r_cmd_speed;
                        r_state      <= S_IDLE;
                    end
                end
                S_T_COR: begin
                    if (cor_done) begin
                        r_c     <= r_flip ? -cor_x : cor_x;
                        r_s     <= r_flip ? -cor_y : cor_y;
                        r_state <= S_T_ST;
                    end
                end
                S_T_ST: begin
                    r_st    <= $signed(r_prod[32:0]);
                    r_state <= S_T_XL;
                end
                S_T_XL: begin
                    r_acc   <= 68'(r_prod);
                    r_state <= S_T_XH;
                end
                S_T_XH: begin
                    r_dx    <= sh_xy[33:0];
                    r_state <= S_T_YL;
                end
                S_T_YL: begin
                    r_acc   <= 68'(r_prod);
                    r_state <= S_T_YH;
                end
                S_T_YH: begin
                    r_dy    <= sh_xy[33:0];
                    r_state <= S_T_YAW;
                end
                S_T_YAW: begin
                    r_dyaw  <= yaw_sh[16:0];
                    r_state <= S_T_FIN;
                end
                S_T_FIN: begin
                    if (out_free) begin
                        r_pos_x      <= px_sat;
                        r_pos_y      <= py_sat;
                        r_yaw        <= y4[14:0];
                        r_speed      <= r_pend_speed;
                        r_yaw_rate   <= r_pend_yaw_rate;
                        r_o_x        <= px_sat;
                        r_o_y        <= py_sat;
                        r_o_heading  <= y4[14:0];
                        r_o_speed    <= r_pend_speed;
                        r_o_yaw_rate <= r_pend_yaw_rate;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pos_x        = r_o_x;
    assign o_pos_y        = r_o_y;
    assign o_heading      = r_o_heading;
    assign o_speed_out    = r_o_speed;
    assign o_yaw_rate_out = r_o_yaw_rate;

endmodule

### rtl/boi_cordic.sv
// rotation-mode cordic, one micro-rotation per cycle
// depends on boi_pkg
module boi_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  boi_pkg::t_cor_req             i_req,
    output logic                          o_done,
    output logic signed [boi_pkg::CW-1:0] o_x,
    output logic signed [boi_pkg::CW-1:0] o_y
);

    logic signed [boi_pkg::CW-1:0] r_x, r_y, r_z;
    logic [boi_pkg::CNT_W-1:0]     r_i;
    logic                          r_busy;
    logic                          r_done;
    logic signed [boi_pkg::CW-1:0] sx, sy, ang;

    always_comb begin
        sx  = r_y >>> r_i;
        sy  = r_x >>> r_i;
        ang = boi_pkg::atan_q30(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_x    <= i_req.x0;
                r_y    <= '0;
                r_z    <= i_req.z0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - sx;
                    r_y <= r_y + sy;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + sx;
                    r_y <= r_y - sy;
                    r_z <= r_z + ang;
                end
                if (r_i == boi_pkg::CNT_W'(boi_pkg::CORDIC_ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

### rtl/boi_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on boi_pkg
module boi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  boi_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [boi_pkg::DIV_W-1:0]    o_quo
);

    logic [boi_pkg::DIV_W-1:0]  r_quo;
    logic [boi_pkg::DVS_W-1:0]  r_rem;
    logic [boi_pkg::DVS_W-1:0]  r_dvs;
    logic [boi_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [boi_pkg::DVS_W:0]    rem_sh;
    logic [boi_pkg::DVS_W:0]    rem_sub;
    logic                       ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[boi_pkg::DIV_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[boi_pkg::DVS_W-1:0] : rem_sh[boi_pkg::DVS_W-1:0];
                r_quo <= {r_quo[boi_pkg::DIV_W-2:0], ge};
                if (r_cnt == boi_pkg::DCNT_W'(boi_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/boi_checker.sv
// port-level checks for the odometry integrator, bound to the top level
// depends on bicycle_odometry_integrator ports only
module boi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_pos_x,
    input logic signed [14:0] o_heading
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_pos_x) && $stable(o_heading)))
        else $error("stalled item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready after accepted item");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading >= -15'sd12867 && o_heading <= 15'sd12868))
        else $error("heading out of range");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without work");

endmodule

bind bicycle_odometry_integrator boi_checker u_boi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pos_x     (o_pos_x),
    .o_heading   (o_heading)
);
